// ===== src/fds_pkg.sv =====
// Shared types and constants for the frequency distribution statistics block.
package fds_pkg;

  localparam int KIND_W = 3;
  localparam int VA_W   = 24;
  localparam int VB_W   = 18;
  localparam int TALLY_W = 7;
  localparam int CFG_W  = 5;
  localparam logic [CFG_W-1:0] CLASS_RESET = 5'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLASS  = 3'd0,
    KIND_MINMAX = 3'd1,
    KIND_RANGE  = 3'd2,
    KIND_MEAN   = 3'd3,
    KIND_MODE   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [VA_W-1:0]      value_a;
    logic [VB_W-1:0]      value_b;
    logic [TALLY_W-1:0]   tally;
    logic                 last_result;
  } res_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_WDIV, ST_CROW, ST_CEMIT, ST_SORT, ST_SUMDIV,
    ST_MED, ST_MODE, ST_EMIT, ST_WAIT
  } state_e;

endpackage

// ===== src/fds_if.sv =====
// Valid/ready channel carrying one word of payload.
interface fds_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/fds_div.sv =====
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
module fds_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] d_q, d_d;
  logic [CW-1:0] c_q, c_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; c_d = c_q; busy_d = busy_q;
    done_d = 1'b0;
    trial = {r_q, q_q[NW-1]};
    if (start_i) begin
      q_d = num_i; r_d = '0; d_d = den_i; c_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        r_d = DW'(trial - {1'b0, d_q});
        q_d = {q_q[NW-2:0], 1'b1};
      end else begin
        r_d = trial[DW-1:0];
        q_d = {q_q[NW-2:0], 1'b0};
      end
      c_d = c_q - 1'b1;
      if (c_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      c_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      c_q <= c_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
  end

  assign quo_o = q_q;
  assign done_o = done_q;
endmodule

// ===== src/frequency_distribution_stats.sv =====
// Top level of the frequency distribution statistics block.
// Usage:
//   cfg: write class_count (1..16) while idle; 0 acts as 1, above the
//        class limit acts as the limit.
//   in:  one sample word per cycle while loading; last_sample closes the set.
//        Samples beyond MAX_SAMPLES are dropped.
//   out: class rows, then min/max, range/width, mean/median and mode
//        (last_result set on mode).
// After the last sample the block is busy: a width division, one scan of the
// store per class row, an insertion sort in place in the sample memory, a mean
// division on the same divider, median reads, one pass over the sorted store
// for the mode and 4 summary words.
// Each result is held in an output register until taken; a stalled receiver
// stalls the sequencer. Reset clears counters and sets class_count to 5;
// the sample memory is not cleared.
module frequency_distribution_stats #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_CLASSES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  fds_if.sink   cfg,
  fds_if.sink   in_ch,
  fds_if.source out_ch
);
  import fds_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = SAMPLE_BITS + NW;
  localparam int XW  = SAMPLE_BITS + 2;
  localparam int MW  = SW + 9;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_q;

  state_e state_q, state_d;
  logic [CFG_W-1:0] cls_q;
  logic [NW-1:0] n_q, n_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [CFG_W+1:0] k_eff;

  logic signed [XW-1:0] low_q, low_d, width_q, width_d;
  logic [XW-1:0] range_u;
  logic [NW:0] i_q, i_d, j_q, j_d;
  logic [NW-1:0] cnt_q, cnt_d, best_q, best_d, run_q, run_d;
  logic signed [SAMPLE_BITS-1:0] key_q, key_d, prev_q, prev_d, mode_q, mode_d;
  logic signed [XW-1:0] med_q, med_d;
  logic signed [MW-1:0] mean_q, mean_d;
  logic [2:0] sub_q, sub_d;
  logic [2:0] emit_q, emit_d;

  logic          we;
  logic [AW-1:0] wa, ra;
  logic signed [SAMPLE_BITS-1:0] wd;

  logic        div_go;
  logic [MW-1:0] div_num;
  logic [NW+XW-1:0] div_den;
  logic [MW-1:0] div_quo;
  logic div_done;
  logic neg_q, neg_d;

  res_t res_q, res_d;
  logic ov_q, ov_d;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= CLASS_RESET;
    end else if (cfg.valid) begin
      cls_q <= cfg.data[CFG_W-1:0];
    end
  end

  always_comb begin
    if (cls_q == '0) k_eff = (CFG_W+2)'(1);
    else if (32'(cls_q) > MAX_CLASSES) k_eff = (CFG_W+2)'(MAX_CLASSES);
    else k_eff = (CFG_W+2)'(cls_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  fds_div #(
    .NW(MW),
    .DW(NW+XW)
  ) u_div (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(div_go),
    .num_i(div_num),
    .den_i(div_den),
    .done_o(div_done),
    .quo_o(div_quo)
  );

  assign in_ch.ready = (state_q == ST_LOAD);
  assign out_ch.valid = ov_q;
  assign out_ch.data = res_q;
  logic out_free;
  assign out_free = !ov_q || out_ch.ready;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [XW-1:0] high;
  logic [MW-1:0] absn;
  logic signed [MW-1:0] num_s;
  assign smp = in_ch.data[SAMPLE_BITS:1];
  assign high = low_q + width_q - XW'(1);
  assign range_u = XW'(max_q) - XW'(min_q);
  assign num_s = MW'(sum_q) <<< 8;

  always_comb begin
    state_d = state_q; n_d = n_q; min_d = min_q; max_d = max_q; sum_d = sum_q;
    low_d = low_q; width_d = width_q; i_d = i_q; j_d = j_q; cnt_d = cnt_q;
    best_d = best_q; run_d = run_q; key_d = key_q; prev_d = prev_q;
    mode_d = mode_q; med_d = med_q; mean_d = mean_q; sub_d = sub_q;
    emit_d = emit_q; neg_d = neg_q;
    res_d = res_q; ov_d = ov_q && !out_ch.ready;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    div_go = 1'b0; div_num = '0; div_den = '0;
    absn = num_s[MW-1] ? MW'(-num_s) : MW'(num_s);
    case (state_q)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (32'(n_q) < MAX_SAMPLES) begin
            we = 1'b1; wa = n_q[AW-1:0]; wd = smp;
            if (n_q == '0) begin
              min_d = smp; max_d = smp;
            end else begin
              if (smp < min_q) min_d = smp;
              if (smp > max_q) max_d = smp;
            end
            sum_d = sum_q + SW'(smp);
            n_d = n_q + 1'b1;
          end
          if (in_ch.data[0]) state_d = ST_WDIV;
          sub_d = '0;
        end
      end
      ST_WDIV: begin
        if (sub_q == '0) begin
          div_go = 1'b1;
          div_num = MW'(range_u) + MW'(k_eff) - MW'(1);
          div_den = (NW+XW)'(k_eff);
          sub_d = 3'd1;
        end else if (div_done) begin
          width_d = (div_quo == '0) ? XW'(1) : XW'(div_quo);
          low_d = XW'(min_q);
          state_d = ST_CROW; i_d = '0; cnt_d = '0; sub_d = '0;
        end
      end
      ST_CROW: begin
        // scan memory: read address i, registered data valid in the next cycle
        ra = i_q[AW-1:0];
        if (i_q != '0) begin
          if (XW'(rd_q) >= low_q && XW'(rd_q) <= high) cnt_d = cnt_q + 1'b1;
        end
        if (i_q == (NW+1)'(n_q)) state_d = ST_CEMIT;
        else i_d = i_q + 1'b1;
      end
      ST_CEMIT: begin
        if (out_free) begin
          res_d.kind = KIND_CLASS;
          res_d.value_a = VA_W'(low_q); res_d.value_b = VB_W'(high);
          res_d.tally = TALLY_W'(cnt_q); res_d.last_result = 1'b0;
          ov_d = 1'b1;
          low_d = low_q + width_q;
          i_d = '0; cnt_d = '0;
          if (low_q + width_q > XW'(max_q)) begin
            state_d = ST_SORT; i_d = (NW+1)'(1); sub_d = '0;
          end else state_d = ST_CROW;
        end
      end
      ST_SORT: begin
        // insertion sort: read key, then walk j down
        if (i_q >= (NW+1)'(n_q)) begin
          state_d = ST_SUMDIV; sub_d = '0;
        end else case (sub_q)
          3'd0: begin ra = i_q[AW-1:0]; sub_d = 3'd1; end
          3'd1: begin
            key_d = rd_q; j_d = i_q; ra = AW'(i_q - 1'b1); sub_d = 3'd2;
          end
          3'd2: begin
            if (j_q != '0 && rd_q > key_q) begin
              we = 1'b1; wa = j_q[AW-1:0]; wd = rd_q;
              j_d = j_q - 1'b1;
              ra = AW'(j_q - 2'd2);
              if (j_q == (NW+1)'(1)) sub_d = 3'd3;
            end else sub_d = 3'd3;
          end
          default: begin
            we = 1'b1; wa = j_q[AW-1:0]; wd = key_q;
            i_d = i_q + 1'b1; sub_d = 3'd0;
          end
        endcase
      end
      ST_SUMDIV: begin
        if (sub_q == '0) begin
          div_go = 1'b1; div_num = absn; div_den = (NW+XW)'(n_q);
          neg_d = num_s[MW-1]; sub_d = 3'd1;
        end else if (div_done) begin
          mean_d = neg_q ? -$signed(div_quo) : $signed(div_quo);
          state_d = ST_MED; sub_d = '0;
        end
      end
      ST_MED: begin
        case (sub_q)
          3'd0: begin ra = AW'(n_q >> 1); sub_d = 3'd1; end
          3'd1: begin
            ra = AW'((n_q >> 1) - 1'b1);
            med_d = XW'(rd_q);
            sub_d = 3'd2;
          end
          default: begin
            if (n_q[0]) med_d = med_q + med_q;
            else med_d = med_q + XW'(rd_q);
            state_d = ST_MODE; i_d = '0; best_d = '0; run_d = '0; sub_d = '0;
          end
        endcase
      end
      ST_MODE: begin
        // runs in sorted data; first longest run is the smallest value
        ra = i_q[AW-1:0];
        if (i_q != '0) begin
          if (i_q != (NW+1)'(1) && rd_q == prev_q) run_d = run_q + 1'b1;
          else run_d = NW'(1);
          prev_d = rd_q;
          if ((i_q != (NW+1)'(1) && rd_q == prev_q ? run_q + 1'b1 : NW'(1)) > best_q) begin
            best_d = (i_q != (NW+1)'(1) && rd_q == prev_q) ? run_q + 1'b1 : NW'(1);
            mode_d = rd_q;
          end
        end
        if (i_q == (NW+1)'(n_q)) begin
          state_d = ST_EMIT; emit_d = '0;
        end else i_d = i_q + 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; res_d.last_result = 1'b0;
          case (emit_q)
            3'd0: begin
              res_d.kind = KIND_MINMAX; res_d.value_a = VA_W'(min_q);
              res_d.value_b = VB_W'(max_q); res_d.tally = TALLY_W'(n_q);
            end
            3'd1: begin
              res_d.kind = KIND_RANGE; res_d.value_a = VA_W'(range_u);
              res_d.value_b = VB_W'(width_q); res_d.tally = TALLY_W'(k_eff);
            end
            3'd2: begin
              res_d.kind = KIND_MEAN; res_d.value_a = VA_W'(mean_q);
              res_d.value_b = VB_W'(med_q); res_d.tally = '0;
            end
            default: begin
              res_d.kind = KIND_MODE; res_d.value_a = VA_W'(mode_q);
              res_d.value_b = '0; res_d.tally = TALLY_W'(best_q);
              res_d.last_result = 1'b1;
              n_d = '0; min_d = '0; max_d = '0; sum_d = '0;
              state_d = ST_LOAD;
            end
          endcase
          emit_d = emit_q + 1'b1;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; n_q <= '0; min_q <= '0; max_q <= '0; sum_q <= '0;
      ov_q <= 1'b0; sub_q <= '0; emit_q <= '0; i_q <= '0;
    end else begin
      state_q <= state_d; n_q <= n_d; min_q <= min_d; max_q <= max_d;
      sum_q <= sum_d; ov_q <= ov_d; sub_q <= sub_d;
      emit_q <= emit_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d; width_q <= width_d; j_q <= j_d; cnt_q <= cnt_d;
    best_q <= best_d; run_q <= run_d; key_q <= key_d; prev_q <= prev_d;
    mode_q <= mode_d; med_q <= med_d; mean_q <= mean_d; neg_q <= neg_d;
    res_q <= res_d;
  end
endmodule

// ===== tb/sv/frequency_distribution_stats_tb.sv =====
// Testbench for frequency_distribution_stats: directed and random sample sets against a predictor.
`timescale 1ns / 100ps

module frequency_distribution_stats_tb;
  import fds_pkg::*;

  localparam int NSAMP = 64;
  localparam int NCLS = 16;
  localparam int IDLE_LIMIT = 20000;

  class stats_board;
    logic signed [15:0] held[NSAMP];
    int held_n;
    int lo_v, hi_v, total;
    logic [CFG_W-1:0] classes;
    res_t due[$];
    int errors;

    function void set_classes(logic [CFG_W-1:0] v);
      classes = v;
    endfunction

    function void push_res(kind_e k, int a, int b, int t, bit l);
      res_t r;
      r.kind = k;
      r.value_a = a[VA_W-1:0];
      r.value_b = b[VB_W-1:0];
      r.tally = t[TALLY_W-1:0];
      r.last_result = l;
      due.push_back(r);
    endfunction

    function void note_word(logic signed [15:0] s, bit last);
      int k, span, w, lo, cnt, mean, med2, mode_v, best, c, j;
      logic signed [15:0] v;
      logic signed [15:0] srt[NSAMP];
      if (held_n < NSAMP) begin
        if (held_n == 0) begin
          lo_v = s;
          hi_v = s;
        end else begin
          if (s < lo_v) lo_v = s;
          if (s > hi_v) hi_v = s;
        end
        total += s;
        held[held_n] = s;
        held_n++;
      end
      if (!last) return;
      k = (classes == 0) ? 1 : (classes > NCLS) ? NCLS : classes;
      span = hi_v - lo_v;
      w = (span + k - 1) / k;
      if (w < 1) w = 1;
      for (lo = lo_v; lo <= hi_v; lo += w) begin
        cnt = 0;
        for (int i = 0; i < held_n; i++)
          if (held[i] >= lo && held[i] <= lo + w - 1) cnt++;
        push_res(KIND_CLASS, lo, lo + w - 1, cnt, 1'b0);
      end
      for (int i = 0; i < held_n; i++) srt[i] = held[i];
      for (int i = 1; i < held_n; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      mean = (total * 256) / held_n;
      if (held_n % 2 == 0) med2 = srt[held_n/2-1] + srt[held_n/2];
      else med2 = 2 * srt[held_n/2];
      best = 0;
      mode_v = 0;
      for (int i = 0; i < held_n; i++) begin
        c = 0;
        for (int m = i; m < held_n; m++) if (srt[m] == srt[i]) c++;
        if (c > best) begin
          best = c;
          mode_v = srt[i];
        end
      end
      push_res(KIND_MINMAX, lo_v, hi_v, held_n, 1'b0);
      push_res(KIND_RANGE, span, w, k, 1'b0);
      push_res(KIND_MEAN, mean, med2, 0, 1'b0);
      push_res(KIND_MODE, mode_v, 0, best, 1'b1);
      held_n = 0;
      lo_v = 0;
      hi_v = 0;
      total = 0;
    endfunction

    function void check_word(res_t got);
      res_t e;
      if (due.size() == 0) begin
        $error("unexpected word %h", got);
        errors++;
        return;
      end
      e = due.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, got.kind); errors++;
      end
      if (got.value_a !== e.value_a) begin
        $error("value_a: expected %h actual %h", e.value_a, got.value_a); errors++;
      end
      if (got.value_b !== e.value_b) begin
        $error("value_b: expected %h actual %h", e.value_b, got.value_b); errors++;
      end
      if (got.tally !== e.tally) begin
        $error("tally: expected %0d actual %0d", e.tally, got.tally); errors++;
      end
      if (got.last_result !== e.last_result) begin
        $error("last_result: expected %b actual %b", e.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit hold_req;
  bit calm;
  int idle_cycles;
  int words_sent;
  stats_board board;

  fds_if #(.W(CFG_W)) cfg ();
  fds_if #(.W(17)) in_ch ();
  fds_if #(.W($bits(res_t))) out_ch ();

  frequency_distribution_stats uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg(cfg),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic signed [15:0] s, bit last);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= {s, last};
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_word(s, last);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_classes(logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    board.set_classes(v);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_set(int len, int mode_sel);
    int base, v;
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      if (mode_sel == 0) v = $urandom_range(0, 65535);
      else v = base + $urandom_range(0, 7 * mode_sel);
      send_word(v[15:0], i == len - 1);
    end
  endtask

  initial begin
    res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        board.check_word(got);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] cls_pick[6];
    board = new();
    board.classes = CLASS_RESET;
    cls_pick = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd3};
    calm = 1'b0;
    hold_req = 1'b0;
    words_sent = 0;
    rst_ni <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(16'sh7fff, 1'b1);
    send_word(-16'sh8000, 1'b1);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
    write_classes(5'd0);
    for (int i = 0; i < 4; i++) send_word(16'sd42, i == 3);
    write_classes(5'd31);
    send_word(16'sd1, 1'b0);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(-16'sd3, 1'b0);
    send_word(16'sd9, 1'b1);
    write_classes(5'd16);
    calm = 1'b1;
    for (int i = 0; i < 66; i++) send_word(-16'sh8000, i == 65);
    hold_req = 1'b1;
    for (int i = 0; i < 70; i++) send_word(16'($urandom_range(0, 65535)), i == 69);
    calm = 1'b0;

    while (words_sent < 460) begin
      int r, len;
      if ($urandom_range(0, 5) == 0) write_classes(CFG_W'($urandom_range(0, 5) < 3 ?
          cls_pick[$urandom_range(0, 5)] : $urandom_range(0, 31)));
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      len = (r < 80) ? $urandom_range(1, 16) : (r < 95) ? $urandom_range(17, 64)
          : $urandom_range(65, 72);
      send_set(len, $urandom_range(0, 3));
    end
    in_ch.valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
